FILE: rtl/hdc_pkg.sv
// ----------------------------------------------------------------------------
// Dynamic code package
// Types, constants and bound tables shared by the dynamic code block.
// ----------------------------------------------------------------------------
package hdc_pkg;

  localparam int unsigned SUM_W     = 64;
  localparam int unsigned CODE_W    = 40;
  localparam int unsigned REM_W     = CODE_W + 1;
  localparam int unsigned HALF_W    = SUM_W / 2;
  localparam int unsigned ACC_W     = SUM_W + REM_W;
  localparam int unsigned DIGITS_W  = 4;
  localparam int unsigned MOD_STEPS = 9;
  localparam int unsigned CNT_W     = $clog2(MOD_STEPS);
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned DATA_W    = 32;

  localparam logic [CNT_W-1:0]    CNT_LAST       = CNT_W'(MOD_STEPS - 1);
  localparam logic [DIGITS_W-1:0] DIGITS_RESET   = 4'd8;
  localparam logic                REG_CODE_DIGITS = 1'b0;

  localparam logic [CNT_W-1:0] STEP_QUO_LL  = CNT_W'(0);
  localparam logic [CNT_W-1:0] STEP_QUO_LH  = CNT_W'(1);
  localparam logic [CNT_W-1:0] STEP_QUO_HL  = CNT_W'(2);
  localparam logic [CNT_W-1:0] STEP_QUO_HH  = CNT_W'(3);
  localparam logic [CNT_W-1:0] STEP_BACK_LL = CNT_W'(4);
  localparam logic [CNT_W-1:0] STEP_BACK_LH = CNT_W'(5);
  localparam logic [CNT_W-1:0] STEP_BACK_HL = CNT_W'(6);
  localparam logic [CNT_W-1:0] STEP_SUB     = CNT_W'(7);
  localparam logic [CNT_W-1:0] STEP_FIX     = CNT_W'(8);

  // Reciprocals of the upper primes, scaled by two to the power of the sum
  // width and rounded down.
  localparam logic [SUM_W:0]   SUM_RANGE = {1'b1, {SUM_W{1'b0}}};
  localparam logic [SUM_W-1:0] RECIP_6   = SUM_W'(SUM_RANGE / 40'd899981);
  localparam logic [SUM_W-1:0] RECIP_8   = SUM_W'(SUM_RANGE / 40'd89999969);
  localparam logic [SUM_W-1:0] RECIP_10  = SUM_W'(SUM_RANGE / 40'd8999999929);
  localparam logic [SUM_W-1:0] RECIP_12  = SUM_W'(SUM_RANGE / 40'd899999999981);

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_UNSUP = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MOD  = 2'd1,
    ST_DONE = 2'd2
  } state_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [CODE_W-1:0] code_value;
    logic [1:0]        status;
  } out_t;

  typedef struct packed {
    logic hash_en;
    logic mod_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mod_done;
  } dp_stat_t;

  function automatic status_e status_of(input logic [DIGITS_W-1:0] digits);
    status_e st;
    if (!(digits inside {[4'd4:4'd12]})) begin
      st = STATUS_RANGE;
    end else if (digits inside {4'd6, 4'd8, 4'd10, 4'd12}) begin
      st = STATUS_OK;
    end else begin
      st = STATUS_UNSUP;
    end
    return st;
  endfunction

  function automatic logic [CODE_W-1:0] lower_bound(input logic [DIGITS_W-1:0] digits);
    logic [CODE_W-1:0] lo;
    case (digits)
      4'd6:    lo = 40'd100003;
      4'd8:    lo = 40'd10000019;
      4'd10:   lo = 40'd1000000007;
      4'd12:   lo = 40'd100000000003;
      default: lo = '0;
    endcase
    return lo;
  endfunction

  function automatic logic [CODE_W-1:0] upper_bound(input logic [DIGITS_W-1:0] digits);
    logic [CODE_W-1:0] hi;
    case (digits)
      4'd6:    hi = 40'd899981;
      4'd8:    hi = 40'd89999969;
      4'd10:   hi = 40'd8999999929;
      4'd12:   hi = 40'd899999999981;
      default: hi = 40'd1;
    endcase
    return hi;
  endfunction

  function automatic logic [SUM_W-1:0] recip_of(input logic [DIGITS_W-1:0] digits);
    logic [SUM_W-1:0] m;
    case (digits)
      4'd6:    m = RECIP_6;
      4'd8:    m = RECIP_8;
      4'd10:   m = RECIP_10;
      4'd12:   m = RECIP_12;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/hdc_datapath.sv
// ----------------------------------------------------------------------------
// Dynamic code datapath
// Running hash, multi-cycle reciprocal remainder unit and output register.
// ----------------------------------------------------------------------------
module hdc_datapath import hdc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_cmd_t           cmd_i,
  input  in_t                 in_data_i,
  input  logic [DIGITS_W-1:0] code_digits_i,
  output dp_stat_t            stat_o,
  output out_t                out_data_o
);

  logic [SUM_W-1:0]  hash_sum_q, hash_sum_d;
  logic [SUM_W-1:0]  div_q, div_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  out_t              out_q, out_d;

  logic [SUM_W-1:0]  next_sum;
  logic [SUM_W-1:0]  recip;
  logic [HALF_W-1:0] mul_a;
  logic [HALF_W-1:0] mul_b;
  logic [SUM_W-1:0]  mul_p;
  logic [CODE_W-1:0] hi;
  logic [CODE_W-1:0] lo;
  status_e           st;

  assign hi    = upper_bound(code_digits_i);
  assign lo    = lower_bound(code_digits_i);
  assign st    = status_of(code_digits_i);
  assign recip = recip_of(code_digits_i);

  // Multiplication by 257 is a shift by eight plus the sum itself.
  assign next_sum  = {hash_sum_q[SUM_W-9:0], 8'd0} + hash_sum_q
                   + {{(SUM_W-8){1'b0}}, in_data_i.data_byte};

  // The quotient estimate is the sum times the scaled reciprocal, shifted down
  // by the sum width; it is at most one below the true quotient, so the
  // remainder taken modulo two to the power of REM_W needs one final correction.
  assign mul_p = SUM_W'(mul_a) * SUM_W'(mul_b);

  always_comb begin
    mul_a = div_q[HALF_W-1:0];
    mul_b = recip[HALF_W-1:0];
    case (cnt_q)
      STEP_QUO_LH: begin
        mul_b = recip[SUM_W-1:HALF_W];
      end
      STEP_QUO_HL: begin
        mul_a = div_q[SUM_W-1:HALF_W];
      end
      STEP_QUO_HH: begin
        mul_a = div_q[SUM_W-1:HALF_W];
        mul_b = recip[SUM_W-1:HALF_W];
      end
      STEP_BACK_LL: begin
        mul_a = acc_q[SUM_W+HALF_W-1:SUM_W];
        mul_b = hi[HALF_W-1:0];
      end
      STEP_BACK_LH: begin
        mul_a = acc_q[SUM_W+HALF_W-1:SUM_W];
        mul_b = HALF_W'(hi[CODE_W-1:HALF_W]);
      end
      STEP_BACK_HL: begin
        mul_a = HALF_W'(acc_q[ACC_W-1:SUM_W+HALF_W]);
        mul_b = hi[HALF_W-1:0];
      end
      default: begin
        mul_a = div_q[HALF_W-1:0];
      end
    endcase
  end

  always_comb begin
    hash_sum_d = hash_sum_q;
    div_d      = div_q;
    acc_d      = acc_q;
    rem_d      = rem_q;
    cnt_d      = cnt_q;
    out_d      = out_q;
    if (cmd_i.hash_en) begin
      if (in_data_i.last_byte) begin
        hash_sum_d = '0;
        div_d      = next_sum;
        rem_d      = '0;
        cnt_d      = '0;
      end else begin
        hash_sum_d = next_sum;
      end
    end
    if (cmd_i.mod_step) begin
      case (cnt_q)
        STEP_QUO_LL: begin
          acc_d = ACC_W'(mul_p);
        end
        STEP_QUO_LH, STEP_QUO_HL: begin
          acc_d = acc_q + ACC_W'({mul_p, {HALF_W{1'b0}}});
        end
        STEP_QUO_HH: begin
          acc_d = acc_q + {mul_p[REM_W-1:0], {SUM_W{1'b0}}};
        end
        STEP_BACK_LL: begin
          rem_d = mul_p[REM_W-1:0];
        end
        STEP_BACK_LH, STEP_BACK_HL: begin
          rem_d = rem_q + {mul_p[REM_W-HALF_W-1:0], {HALF_W{1'b0}}};
        end
        STEP_SUB: begin
          rem_d = div_q[REM_W-1:0] - rem_q;
        end
        STEP_FIX: begin
          if (rem_q >= {1'b0, hi}) begin
            rem_d = rem_q - {1'b0, hi};
          end
        end
        default: begin
          acc_d = acc_q;
        end
      endcase
      cnt_d = cnt_q + 1'b1;
    end
    if (cmd_i.out_load) begin
      out_d.status     = st;
      out_d.code_value = (st == STATUS_OK) ? rem_q[CODE_W-1:0] + lo : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_sum_q <= '0;
      cnt_q      <= '0;
    end else begin
      hash_sum_q <= hash_sum_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
    out_q <= out_d;
  end

  assign stat_o.mod_done = (cnt_q == CNT_LAST);
  assign out_data_o      = out_q;

endmodule

FILE: rtl/hdc_ctrl.sv
// ----------------------------------------------------------------------------
// Dynamic code controller
// Sequences byte intake, the remainder pass and the output handshake.
// ----------------------------------------------------------------------------
module hdc_ctrl import hdc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_last_i,
  input  logic      out_stall_i,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o,
  output logic      in_stall_o,
  output logic      out_valid_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.hash_en = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (stat_i.mod_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/hash_to_dynamic_code.sv
// ----------------------------------------------------------------------------
// Dynamic code generator
// Rolling base-257 hash of a byte stream, reduced to a decimal code.
// ----------------------------------------------------------------------------
// The input channel carries one message byte per transaction together with a
// flag that marks the final byte. Bytes that are not final are taken one per
// cycle. A final byte closes the message: the sum is reduced modulo the upper
// prime by a reciprocal multiplication on one shared 32 by 32 bit multiplier,
// which forms the quotient estimate from partial products, multiplies it back
// by the prime, subtracts that from the sum and corrects the remainder once;
// the output register is then loaded when it is free. The input is stalled
// after a final byte until that load, and the code is then valid on the
// output channel. The code width is set by the code_digits register on the
// APB port, which resets to eight and should be written only while the block
// is idle. Reset clears the running sum and drops any pending result. While
// the receiver stalls, the result is held in the output register and the next
// message may be taken in full and reduced; its code then waits, with the
// input stalled, until the held result has been taken.
// ----------------------------------------------------------------------------
module hash_to_dynamic_code import hdc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_t               in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_t              out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [DIGITS_W-1:0] code_digits_q, code_digits_d;
  logic                reg_sel;
  ctrl_cmd_t           cmd;
  dp_stat_t            stat;

  assign reg_sel = (paddr[ADDR_W-1] == REG_CODE_DIGITS);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {{(DATA_W-DIGITS_W){1'b0}}, code_digits_q} : '0;

  always_comb begin
    code_digits_d = code_digits_q;
    if (psel && penable && pwrite && reg_sel) begin
      code_digits_d = pwdata[DIGITS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_digits_q <= DIGITS_RESET;
    end else begin
      code_digits_q <= code_digits_d;
    end
  end

  hdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.last_byte),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  hdc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .in_data_i     (in_data_i),
    .code_digits_i (code_digits_q),
    .stat_o        (stat),
    .out_data_o    (out_data_o)
  );

`ifndef NO_ASSERTIONS
  a_ok_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == STATUS_OK) |-> out_data_o.code_value != '0)
    else $error("Successful code of zero.");

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != STATUS_OK) |-> out_data_o.code_value == '0)
    else $error("Failed code carries a value.");

  a_last_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.last_byte |=> in_stall_o)
    else $error("Input not stalled during the remainder pass.");

  a_result_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.last_byte && !out_valid_o |-> ##11 out_valid_o)
    else $error("Result missing after the remainder pass.");
`endif

endmodule
